FILE: design/swrl_pkg.sv
// Shared types and constants for the sliding window rate limiter.
// Holds the bin entry layout, the sequencer states and register indexes.
// No dependencies.
package swrl_pkg;

  localparam int BINS_DEFAULT = 64;
  localparam int TIME_W       = 32;
  localparam int COUNT_W      = 16;
  localparam int LIMIT_W      = 16;
  localparam int WINDOW_W     = 6;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  tag;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SLOT,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REQUEST_LIMIT  = 1'b0,
    REG_WINDOW_SECONDS = 1'b1
  } cfg_reg_t;

endpackage

FILE: design/swrl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Width and depth are parameters. No dependencies.
module swrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sliding_window_rate_limiter.sv
// Sliding window rate limiter: one request per transfer, one grant decision back.
// Each request scans every bin over the RAM read port, clearing entries older than the window
// and summing the rest, then reads its slot and, if granted, updates it. One request at a time:
// in_stall holds off the next transfer until the result of the last one is put on the output.
// After reset a clearing pass empties the bin RAM; no request is taken then, configuration
// writes are. Depends on swrl_pkg and swrl_ram.
module sliding_window_rate_limiter #(
  parameter int BINS = swrl_pkg::BINS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [swrl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [swrl_pkg::TIME_W-1:0]        now_seconds,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               granted,
  output logic [swrl_pkg::COUNT_W-1:0]       window_count
);

  import swrl_pkg::*;

  localparam int AW      = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CW      = $clog2(BINS + 1);
  localparam int EW      = $bits(entry_t);
  localparam int MUL_W   = 2 * TIME_W;
  localparam int QUOT_SH = AW - 1;
  localparam logic [MUL_W-1:0] MAGIC_WIDE =
    (((MUL_W'(1) << AW) - MUL_W'(BINS)) << TIME_W) / MUL_W'(BINS) + MUL_W'(1);
  localparam logic [TIME_W-1:0] MAGIC   = TIME_W'(MAGIC_WIDE);
  localparam logic [AW-1:0]     BINS_LO = AW'(BINS);

  state_t              state, state_next;
  logic [CW-1:0]       scan_cnt, scan_cnt_next;
  logic                rd_pend, rd_pend_next;
  logic [AW-1:0]       rd_addr, rd_addr_next;
  logic [TIME_W-1:0]   now_q, now_q_next;
  logic [TIME_W-1:0]   begin_q, begin_q_next;
  logic [COUNT_W-1:0]  sum, sum_next;
  logic [AW-1:0]       rem, rem_next;
  logic [TIME_W-1:0]   mul_hi, mul_hi_next;
  logic [TIME_W-1:0]   quot, quot_next;
  logic                grant, grant_next;
  logic                out_valid_next;
  logic                granted_next;
  logic [COUNT_W-1:0]  window_count_next;
  logic [LIMIT_W-1:0]  request_limit;
  logic [WINDOW_W-1:0] window_seconds;

  logic                we;
  logic [AW-1:0]       waddr;
  entry_t              wdata;
  logic [AW-1:0]       raddr;
  entry_t              rd_data;
  logic [COUNT_W:0]    sum_add;
  logic [MUL_W-1:0]    mul_full;
  logic [AW-1:0]       quot_bins;

  swrl_ram #(
    .WIDTH(EW),
    .DEPTH(BINS)
  ) u_bins (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      request_limit  <= '0;
      window_seconds <= WINDOW_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REQUEST_LIMIT:  request_limit  <= cfg_data[LIMIT_W-1:0];
        REG_WINDOW_SECONDS: window_seconds <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_cnt  <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_cnt  <= scan_cnt_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr      <= rd_addr_next;
    now_q        <= now_q_next;
    begin_q      <= begin_q_next;
    sum          <= sum_next;
    rem          <= rem_next;
    mul_hi       <= mul_hi_next;
    quot         <= quot_next;
    grant        <= grant_next;
    granted      <= granted_next;
    window_count <= window_count_next;
  end

  // The slot index is now_q modulo BINS, found by reciprocal multiplication through the mul_hi, quot and rem registers.
  always_comb begin
    state_next        = state;
    scan_cnt_next     = scan_cnt;
    rd_pend_next      = rd_pend;
    rd_addr_next      = rd_addr;
    now_q_next        = now_q;
    begin_q_next      = begin_q;
    sum_next          = sum;
    grant_next        = grant;
    granted_next      = granted;
    window_count_next = window_count;
    out_valid_next    = out_valid && out_stall;
    we                = 1'b0;
    waddr             = scan_cnt[AW-1:0];
    wdata             = '0;
    raddr             = scan_cnt[AW-1:0];
    sum_add           = {1'b0, sum} + {1'b0, rd_data.count};
    mul_full          = MUL_W'(now_q) * MUL_W'(MAGIC);
    mul_hi_next       = mul_full[MUL_W-1:TIME_W];
    quot_next         = (mul_hi + ((now_q - mul_hi) >> 1)) >> QUOT_SH;
    quot_bins         = quot[AW-1:0] * BINS_LO;
    rem_next          = now_q[AW-1:0] - quot_bins;

    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        if (scan_cnt == CW'(BINS - 1)) begin
          scan_cnt_next = '0;
          state_next    = ST_IDLE;
        end else begin
          scan_cnt_next = scan_cnt + CW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          now_q_next = now_seconds;
          if (now_seconds > TIME_W'(window_seconds)) begin
            begin_q_next = now_seconds - TIME_W'(window_seconds);
          end else begin
            begin_q_next = '0;
          end
          sum_next      = '0;
          scan_cnt_next = '0;
          rd_pend_next  = 1'b0;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_pend_next = (scan_cnt != CW'(BINS));
        rd_addr_next = scan_cnt[AW-1:0];
        if (scan_cnt != CW'(BINS)) begin
          scan_cnt_next = scan_cnt + CW'(1);
        end
        if (rd_pend && rd_data.valid) begin
          if (rd_data.tag < begin_q) begin
            we    = 1'b1;
            waddr = rd_addr;
            wdata = '0;
          end else begin
            sum_next = sum_add[COUNT_W] ? '1 : sum_add[COUNT_W-1:0];
          end
        end
        if (scan_cnt == CW'(BINS) && !rd_pend) begin
          state_next = ST_SLOT;
        end
      end
      ST_SLOT: begin
        raddr      = rem;
        grant_next = (sum < request_limit);
        state_next = (sum < request_limit) ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        we    = 1'b1;
        waddr = rem;
        if (rd_data.valid && rd_data.tag == now_q) begin
          wdata = rd_data;
          if (rd_data.count != '1) begin
            wdata.count = rd_data.count + COUNT_W'(1);
          end
        end else begin
          wdata.valid = 1'b1;
          wdata.tag   = now_q;
          wdata.count = COUNT_W'(1);
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          granted_next      = grant;
          window_count_next = sum;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
